// ----- design/assert_macros.svh -----
// assertion helpers used by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock unless reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/rgrst_pkg.sv -----
// ----------------------------------------------------------------------------
// rgrst_pkg
// shared widths, codes and types of the goal rule set table
// ----------------------------------------------------------------------------
package rgrst_pkg;

   localparam int GoalCount  = 64;
   localparam int RuleCount  = 64;
   localparam int TrailDepth = 1024;
   localparam int FrameDepth = 32;

   localparam int GoalW  = 6;
   localparam int RuleW  = 6;
   localparam int TrailW = $clog2(TrailDepth);
   localparam int CountW = TrailW + 1;
   localparam int FrameW = $clog2(FrameDepth);
   localparam int FDepW  = FrameW + 1;
   localparam int SetW   = 64;
   localparam int ActW   = 2 + GoalW + RuleW;

   typedef enum logic [2:0] {
      MODE_GET    = 3'd0,
      MODE_ADD    = 3'd1,
      MODE_LINK   = 3'd2,
      MODE_UNLINK = 3'd3,
      MODE_REMOVE = 3'd4,
      MODE_PUSH   = 3'd5,
      MODE_POP    = 3'd6,
      MODE_NONE   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_LINK   = 2'd1,
      KIND_UNLINK = 2'd2,
      KIND_REMOVE = 2'd3
   } kind_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ABSENT  = 3'd1;
   localparam logic [2:0] ST_PRESENT = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_FRAME   = 3'd4;

   // one trail write request
   typedef struct packed {
      logic              we;
      logic [TrailW-1:0] addr;
      logic [ActW-1:0]   action;
      logic [SetW-1:0]   saved;
   } trail_wr_type;

endpackage

// ----- design/reversible_goal_rule_set_table_top.sv -----
// ----------------------------------------------------------------------------
// reversible_goal_rule_set_table_top
// goal rule set table with an undo trail and frame marks
// ----------------------------------------------------------------------------
// Usage: drive req_mode, req_goal, req_rule and pulse start while busy is low;
// the item is taken at that edge and busy rises at once. One result appears
// on rsp_rule_set and rsp_status for a single cycle with rsp_valid high; the
// receiver cannot stall, so it must take it then. busy falls in the same
// cycle as the result, so the next item can be taken at the edge ending it.
// Sequence: get, add, link, unlink, remove, push and a rejected pop pass
// through ram read, modify and write, and done before the result, and busy
// stays high until then, so no new item is taken meanwhile. An accepted pop
// then walks the trail one entry at a time (trail ram read, goal ram read,
// write back) until the trail count is down to the frame mark. The trail
// walk is the limit on pop.
// Reset: synchronous, clears present bits, trail count and frame depth; the
// rams need no clearing as every entry is written before it is read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module reversible_goal_rule_set_table_top
   import rgrst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_mode,
   input  logic [GoalW-1:0] req_goal,
   input  logic [RuleW-1:0] req_rule,
   output logic             rsp_valid,
   output logic [SetW-1:0]  rsp_rule_set,
   output logic [2:0]       rsp_status
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_TREAD, S_GREAD, S_UNDO, S_DONE
   } state_type;

   state_type         state_ff;
   mode_type          mode_ff;
   logic [GoalW-1:0]  goal_ff;
   logic [RuleW-1:0]  rule_ff;
   logic [CountW-1:0] count_ff;
   logic [FDepW-1:0]  fdep_ff;
   logic [CountW-1:0] mark_ff;
   logic [CountW-1:0] marks_mem [FrameDepth];
   logic [CountW-1:0] mark_rd_ff;
   logic [SetW-1:0]   set_ff;
   logic [2:0]        status_ff;
   logic              valid_ff;
   logic [ActW-1:0]   act_ff;
   logic [SetW-1:0]   saved_ff;
   logic [SetW-1:0]   set_in;
   logic [2:0]        status_in;

   logic [GoalW-1:0]  g_rd_goal;
   logic [SetW-1:0]   g_rd_set;
   logic              g_rd_present;
   logic              g_wr_en;
   logic [GoalW-1:0]  g_wr_goal;
   logic [SetW-1:0]   g_wr_set;
   logic              g_pres_en;
   logic              g_pres_val;
   trail_wr_type      t_wr;
   logic [TrailW-1:0] t_rd_addr;
   logic [ActW-1:0]   t_rd_action;
   logic [SetW-1:0]   t_rd_saved;

   logic              room;
   logic [SetW-1:0]   bit_mask;
   logic              bit_set;
   kind_type          u_kind;
   logic [GoalW-1:0]  u_goal;
   logic [SetW-1:0]   u_mask;
   logic [FrameW-1:0] fdep_m1;

   assign room     = (count_ff < CountW'(TrailDepth));
   assign bit_mask = SetW'(1) << rule_ff;
   assign bit_set  = |(g_rd_set & bit_mask);
   assign u_kind   = kind_type'(act_ff[ActW-1:ActW-2]);
   assign u_goal   = act_ff[ActW-3:RuleW];
   assign u_mask   = SetW'(1) << act_ff[RuleW-1:0];
   assign fdep_m1  = FrameW'(fdep_ff - FDepW'(1));
   assign t_rd_addr = TrailW'(count_ff - CountW'(1));
   assign g_rd_goal = (state_ff == S_GREAD) ? t_rd_action[ActW-3:RuleW] : goal_ff;

   always_comb begin
      g_wr_en    = 1'b0;
      g_wr_goal  = goal_ff;
      g_wr_set   = '0;
      g_pres_en  = 1'b0;
      g_pres_val = 1'b0;
      t_wr.we     = 1'b0;
      t_wr.addr   = TrailW'(count_ff);
      t_wr.action = '0;
      t_wr.saved  = g_rd_set;
      if (state_ff == S_EXEC) begin
         unique case (mode_ff)
            MODE_ADD: begin
               if (!g_rd_present && room) begin
                  g_wr_en = 1'b1; g_pres_en = 1'b1; g_pres_val = 1'b1;
                  t_wr.we = 1'b1; t_wr.action = {KIND_ADD, goal_ff, RuleW'(0)};
               end
            end
            MODE_LINK, MODE_UNLINK: begin
               if (g_rd_present && room && ((mode_ff == MODE_LINK) != bit_set)) begin
                  g_wr_en  = 1'b1;
                  g_wr_set = g_rd_set ^ bit_mask;
                  t_wr.we  = 1'b1;
                  t_wr.action = {(mode_ff == MODE_LINK) ? KIND_LINK : KIND_UNLINK,
                                 goal_ff, rule_ff};
               end
            end
            MODE_REMOVE: begin
               if (g_rd_present && room) begin
                  g_pres_en = 1'b1;
                  t_wr.we = 1'b1; t_wr.action = {KIND_REMOVE, goal_ff, RuleW'(0)};
               end
            end
            default: ;
         endcase
      end else if (state_ff == S_UNDO) begin
         g_wr_goal = u_goal;
         unique case (u_kind)
            KIND_ADD:    begin g_pres_en = 1'b1; end
            KIND_REMOVE: begin
               g_pres_en = 1'b1; g_pres_val = 1'b1;
               g_wr_en = 1'b1; g_wr_set = saved_ff;
            end
            KIND_LINK:   begin g_wr_en = 1'b1; g_wr_set = g_rd_set & ~u_mask; end
            default:     begin g_wr_en = 1'b1; g_wr_set = g_rd_set | u_mask; end
         endcase
      end
   end

   // result of the table step
   always_comb begin
      set_in    = '0;
      status_in = ST_OK;
      unique case (mode_ff)
         MODE_GET: begin
            if (!g_rd_present) status_in = ST_ABSENT;
            else set_in = g_rd_set;
         end
         MODE_ADD: begin
            if (g_rd_present) status_in = ST_PRESENT;
            else if (!room) status_in = ST_FULL;
         end
         MODE_LINK, MODE_UNLINK: begin
            if (!g_rd_present) status_in = ST_ABSENT;
            else if (((mode_ff == MODE_LINK) != bit_set) && !room) status_in = ST_FULL;
         end
         MODE_REMOVE: begin
            if (!g_rd_present) status_in = ST_ABSENT;
            else if (!room) status_in = ST_FULL;
         end
         MODE_PUSH: begin
            if (fdep_ff >= FDepW'(FrameDepth)) status_in = ST_FRAME;
         end
         MODE_POP: begin
            if (fdep_ff == '0) status_in = ST_FRAME;
         end
         default: ;
      endcase
   end

   rgrst_goal_mem u_goal_mem (
      .clock(clock), .reset(reset),
      .rd_goal(g_rd_goal), .rd_set(g_rd_set), .rd_present(g_rd_present),
      .wr_en(g_wr_en), .wr_goal(g_wr_goal), .wr_set(g_wr_set),
      .pres_en(g_pres_en), .pres_val(g_pres_val)
   );

   rgrst_trail_mem u_trail_mem (
      .clock(clock), .wr(t_wr), .rd_addr(t_rd_addr),
      .rd_action(t_rd_action), .rd_saved(t_rd_saved)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && mode_ff == MODE_PUSH && fdep_ff < FDepW'(FrameDepth))
         marks_mem[fdep_ff[FrameW-1:0]] <= count_ff;
      mark_rd_ff <= marks_mem[fdep_m1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         fdep_ff   <= '0;
         valid_ff  <= 1'b0;
         mode_ff   <= MODE_GET;
      end else begin
         valid_ff <= (state_ff == S_DONE);
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff  <= mode_type'(req_mode);
                  goal_ff  <= req_goal;
                  rule_ff  <= req_rule;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               set_ff    <= set_in;
               status_ff <= status_in;
               if (t_wr.we) count_ff <= count_ff + CountW'(1);
               if (mode_ff == MODE_PUSH && status_in == ST_OK)
                  fdep_ff <= fdep_ff + FDepW'(1);
               if (mode_ff == MODE_POP && status_in == ST_OK) begin
                  fdep_ff  <= fdep_ff - FDepW'(1);
                  mark_ff  <= mark_rd_ff;
                  state_ff <= S_TREAD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_TREAD: begin
               if (count_ff > mark_ff) state_ff <= S_GREAD;
               else state_ff <= S_DONE;
            end
            S_GREAD: begin
               act_ff   <= t_rd_action;
               saved_ff <= t_rd_saved;
               count_ff <= count_ff - CountW'(1);
               state_ff <= S_UNDO;
            end
            S_UNDO: state_ff <= S_TREAD;
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_rule_set = set_ff;
   assign rsp_status   = status_ff;

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CountW'(TrailDepth), "trail overflow")
   `ASSERT_CLK(a_fdep_bound, clock, reset, fdep_ff <= FDepW'(FrameDepth), "frame overflow")
   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy, "busy after reset")
endmodule

// ----- design/rgrst_goal_mem.sv -----
// ----------------------------------------------------------------------------
// rgrst_goal_mem
// goal table: rule sets in a synchronous ram, present bits in flops
// ----------------------------------------------------------------------------
module rgrst_goal_mem
   import rgrst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [GoalW-1:0] rd_goal,
   output logic [SetW-1:0]  rd_set,
   output logic             rd_present,
   input  logic             wr_en,
   input  logic [GoalW-1:0] wr_goal,
   input  logic [SetW-1:0]  wr_set,
   input  logic             pres_en,
   input  logic             pres_val
);
   logic [SetW-1:0]      rules_mem [GoalCount];
   logic [GoalCount-1:0] present_ff;
   logic [SetW-1:0]      rd_set_ff;
   logic                 rd_pres_ff;

   always_ff @(posedge clock) begin
      if (wr_en) rules_mem[wr_goal] <= wr_set;
      rd_set_ff  <= rules_mem[rd_goal];
      rd_pres_ff <= present_ff[rd_goal];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (pres_en) begin
         present_ff[wr_goal] <= pres_val;
      end
   end

   assign rd_set     = rd_set_ff;
   assign rd_present = rd_pres_ff;
endmodule

// ----- design/rgrst_trail_mem.sv -----
// ----------------------------------------------------------------------------
// rgrst_trail_mem
// undo trail ram: action word and saved rule set per entry
// ----------------------------------------------------------------------------
module rgrst_trail_mem
   import rgrst_pkg::*;
(
   input  logic              clock,
   input  trail_wr_type      wr,
   input  logic [TrailW-1:0] rd_addr,
   output logic [ActW-1:0]   rd_action,
   output logic [SetW-1:0]   rd_saved
);
   logic [ActW+SetW-1:0] trail_mem [TrailDepth];
   logic [ActW+SetW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.we) trail_mem[wr.addr] <= {wr.action, wr.saved};
      rd_ff <= trail_mem[rd_addr];
   end

   assign rd_action = rd_ff[ActW+SetW-1:SetW];
   assign rd_saved  = rd_ff[SetW-1:0];
endmodule
